/* rtl/gfa_pkg.sv */
// Package: constants, operation codes and modular add/sub helpers for the Goldilocks ALU.
`default_nettype none
package gfa_pkg;
    localparam logic [63:0] P   = 64'hFFFF_FFFF_0000_0001;
    localparam logic [63:0] EPS = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned OP_W = 3;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned STAGES = 6;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_EADD = 3'd3;
    localparam logic [OP_W-1:0] OP_ESUB = 3'd4;
    localparam logic [OP_W-1:0] OP_EMUL = 3'd5;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t canon(input word_t v);
        canon = (v >= P) ? v - P : v;
    endfunction

    function automatic word_t add_mod(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_mod = (s >= {1'b0, P}) ? word_t'(s - {1'b0, P}) : s[WORD_W-1:0];
    endfunction

    function automatic word_t sub_mod(input word_t a, input word_t b);
        sub_mod = (a >= b) ? a - b : a - b + P;
    endfunction
endpackage
`default_nettype wire

/* rtl/gfa_reduce.sv */
// 128-bit to canonical field element reduction using 2^64 = 2^32-1 and 2^96 = -1 mod p.
`default_nettype none
module gfa_reduce
(
    input  wire logic [63:0] hi,
    input  wire logic [63:0] lo,
    output logic [63:0]      res
);
    logic [31:0] hh;
    logic [31:0] hl;
    logic [63:0] t0;
    logic [63:0] t1;
    logic [64:0] t2;
    logic [63:0] t3;

    always_comb
    begin
        hh = hi[63:32];
        hl = hi[31:0];
        t0 = lo - {32'd0, hh};
        if (lo < {32'd0, hh})
        begin
            t0 = t0 - gfa_pkg::EPS;
        end
        t1 = {hl, 32'd0} - {32'd0, hl};
        t2 = {1'b0, t0} + {1'b0, t1};
        t3 = t2[64] ? t2[63:0] + gfa_pkg::EPS : t2[63:0];
        res = gfa_pkg::canon(t3);
    end
endmodule
`default_nettype wire

/* rtl/goldilocks_field_alu_unit.sv */
// Top level: six-stage pipelined Goldilocks base and quadratic extension ALU.
//
//  channel | dir | handshake           | payload
//  s_axis  | in  | s_tvalid / s_tready | s_tdata: operation, x_real, x_imag, y_real, y_imag
//  m_axis  | out | m_tvalid / m_tready | m_tdata: res_real, res_imag
//
// Six register stages: canonicalise, 32x32 partial products, 128-bit sums,
// reduction, times-seven and cross add, final combine. One transaction per
// cycle unless m_tready stalls. Reset clears the valid bits only. Each stage
// holds while the next is full and stalled; empty stages close up bubbles.
`default_nettype none
module goldilocks_field_alu_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [263:0] s_tdata,  // operation[2:0], x_real, x_imag, y_real, y_imag, pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata   // res_real[63:0], res_imag[127:64]
);
    localparam int unsigned STAGES = gfa_pkg::STAGES;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] adv;

    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: canonical operands; w[0]=a, w[1]=b, w[2]=c, w[3]=d
    logic [2:0]  op0_reg;
    logic [63:0] w0_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            op0_reg   <= s_tdata[2:0];
            w0_reg[0] <= gfa_pkg::canon(s_tdata[66:3]);
            w0_reg[1] <= gfa_pkg::canon(s_tdata[130:67]);
            w0_reg[2] <= gfa_pkg::canon(s_tdata[194:131]);
            w0_reg[3] <= gfa_pkg::canon(s_tdata[258:195]);
        end
    end

    // stage 1: products ac, bd, ad, bc as four 32x32 partials each; add/sub results
    logic [63:0] mx [4];
    logic [63:0] my [4];
    logic [2:0]  op1_reg;
    logic [63:0] pp1_reg [4][4];
    logic [63:0] pp1_next [4][4];
    logic [63:0] re1_reg;
    logic [63:0] im1_reg;
    logic [63:0] re1_next;
    logic [63:0] im1_next;

    always_comb
    begin
        mx[0] = w0_reg[0]; my[0] = w0_reg[2];
        mx[1] = w0_reg[1]; my[1] = w0_reg[3];
        mx[2] = w0_reg[0]; my[2] = w0_reg[3];
        mx[3] = w0_reg[1]; my[3] = w0_reg[2];
        for (int i = 0; i < 4; i++)
        begin
            pp1_next[i][0] = {32'd0, mx[i][31:0]}  * {32'd0, my[i][31:0]};
            pp1_next[i][1] = {32'd0, mx[i][31:0]}  * {32'd0, my[i][63:32]};
            pp1_next[i][2] = {32'd0, mx[i][63:32]} * {32'd0, my[i][31:0]};
            pp1_next[i][3] = {32'd0, mx[i][63:32]} * {32'd0, my[i][63:32]};
        end
        if (op0_reg == gfa_pkg::OP_SUB || op0_reg == gfa_pkg::OP_ESUB)
        begin
            re1_next = gfa_pkg::sub_mod(w0_reg[0], w0_reg[2]);
            im1_next = gfa_pkg::sub_mod(w0_reg[1], w0_reg[3]);
        end
        else
        begin
            re1_next = gfa_pkg::add_mod(w0_reg[0], w0_reg[2]);
            im1_next = gfa_pkg::add_mod(w0_reg[1], w0_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            op1_reg <= op0_reg;
            pp1_reg <= pp1_next;
            re1_reg <= re1_next;
            im1_reg <= im1_next;
        end
    end

    // stage 2: full 128-bit products
    logic [2:0]   op2_reg;
    logic [127:0] pr2_reg [4];
    logic [63:0]  re2_reg;
    logic [63:0]  im2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            op2_reg <= op1_reg;
            re2_reg <= re1_reg;
            im2_reg <= im1_reg;
            for (int i = 0; i < 4; i++)
            begin
                pr2_reg[i] <= {64'd0, pp1_reg[i][0]}
                            + {32'd0, pp1_reg[i][1], 32'd0}
                            + {32'd0, pp1_reg[i][2], 32'd0}
                            + {pp1_reg[i][3], 64'd0};
            end
        end
    end

    // stage 3: reduction of each product
    logic [63:0] red3 [4];
    logic [2:0]  op3_reg;
    logic [63:0] md3_reg [4];
    logic [63:0] re3_reg;
    logic [63:0] im3_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_red
        gfa_reduce u_red
        (
            .hi  (pr2_reg[g][127:64]),
            .lo  (pr2_reg[g][63:0]),
            .res (red3[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            op3_reg <= op2_reg;
            md3_reg <= red3;
            re3_reg <= re2_reg;
            im3_reg <= im2_reg;
        end
    end

    // stage 4: 7*bd reduced, ad+bc
    logic [66:0] bd7;
    logic [63:0] bd7_red;
    logic [2:0]  op4_reg;
    logic [63:0] ac4_reg;
    logic [63:0] bd74_reg;
    logic [63:0] cr4_reg;
    logic [63:0] re4_reg;
    logic [63:0] im4_reg;

    assign bd7 = {md3_reg[1], 3'd0} - {3'd0, md3_reg[1]};

    gfa_reduce u_red7
    (
        .hi  ({61'd0, bd7[66:64]}),
        .lo  (bd7[63:0]),
        .res (bd7_red)
    );

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            op4_reg  <= op3_reg;
            ac4_reg  <= md3_reg[0];
            bd74_reg <= bd7_red;
            cr4_reg  <= gfa_pkg::add_mod(md3_reg[2], md3_reg[3]);
            re4_reg  <= re3_reg;
            im4_reg  <= im3_reg;
        end
    end

    // stage 5: result select; ac + 7*bd for the extension multiply
    logic [63:0] res_real_next;
    logic [63:0] res_imag_next;
    logic [63:0] res_real_reg;
    logic [63:0] res_imag_reg;

    always_comb
    begin
        unique case (op4_reg)
            gfa_pkg::OP_ADD, gfa_pkg::OP_SUB:
            begin
                res_real_next = re4_reg;
                res_imag_next = '0;
            end
            gfa_pkg::OP_MUL:
            begin
                res_real_next = ac4_reg;
                res_imag_next = '0;
            end
            gfa_pkg::OP_EADD, gfa_pkg::OP_ESUB:
            begin
                res_real_next = re4_reg;
                res_imag_next = im4_reg;
            end
            gfa_pkg::OP_EMUL:
            begin
                res_real_next = gfa_pkg::add_mod(ac4_reg, bd74_reg);
                res_imag_next = cr4_reg;
            end
            default:
            begin
                res_real_next = '0;
                res_imag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            res_real_reg <= res_real_next;
            res_imag_reg <= res_imag_next;
        end
    end

    assign m_tdata = {res_imag_reg, res_real_reg};
endmodule
`default_nettype wire

/* rtl/gfa_checker.sv */
// Port checker for the Goldilocks ALU, bound to the top level.
`default_nettype none
module gfa_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata
);
    a_real_canon: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:0] < gfa_pkg::P)
        else $error("res_real not reduced");

    a_imag_canon: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[127:64] < gfa_pkg::P)
        else $error("res_imag not reduced");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");
endmodule

bind goldilocks_field_alu_unit gfa_checker u_gfa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* test/goldilocks_field_alu_unit_tb.sv */
// Testbench for the Goldilocks field ALU: directed and random streams against a predictor.
`timescale 1ns / 1ps
module goldilocks_field_alu_unit_tb;

    localparam logic [63:0] PRIME = 64'hFFFF_FFFF_0000_0001;
    localparam int LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [263:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    logic [127:0] expected_results[$];
    int  errors;
    int  cycles;
    bit  idle_off;

    goldilocks_field_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] fold(logic [63:0] v);
        return (v >= PRIME) ? v - PRIME : v;
    endfunction

    function automatic logic [63:0] fadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME})
            s = s - {1'b0, PRIME};
        return s[63:0];
    endfunction

    function automatic logic [63:0] fsub(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : a - b + PRIME;
    endfunction

    function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'((prod % {64'd0, PRIME}));
    endfunction

    function automatic logic [127:0] alu_result(logic [2:0] op, logic [63:0] xr,
        logic [63:0] xi, logic [63:0] yr, logic [63:0] yi);
        logic [63:0] a, b, c, d, re, im;
        a = fold(xr); b = fold(xi); c = fold(yr); d = fold(yi);
        re = 64'd0; im = 64'd0;
        case (op)
            gfa_pkg::OP_ADD:  re = fadd(a, c);
            gfa_pkg::OP_SUB:  re = fsub(a, c);
            gfa_pkg::OP_MUL:  re = fmul(a, c);
            gfa_pkg::OP_EADD: begin re = fadd(a, c); im = fadd(b, d); end
            gfa_pkg::OP_ESUB: begin re = fsub(a, c); im = fsub(b, d); end
            gfa_pkg::OP_EMUL:
            begin
                re = fadd(fmul(a, c), fmul(fmul(b, d), 64'd7));
                im = fadd(fmul(a, d), fmul(b, c));
            end
            default: ;
        endcase
        return {im, re};
    endfunction

    task automatic send_operands(logic [2:0] op, logic [63:0] xr, logic [63:0] xi,
        logic [63:0] yr, logic [63:0] yi);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {5'd0, yi, yr, xi, xr, op};
        s_tvalid <= 1'b1;
        expected_results.push_back(alu_result(op, xr, xi, yr, yi));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [63:0] edge_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return PRIME - 1;
            3: return PRIME;
            4: return PRIME + 1;
            5: return 64'hFFFF_FFFF_FFFF_FFFF;
            6: return 64'h0000_0000_FFFF_FFFF;
            7: return 64'h0000_0001_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        logic [63:0] w[6];
        w = '{64'd0, 64'd1, PRIME - 1, PRIME, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7};
        for (int op = 0; op < 8; op++)
        begin
            send_operands(3'(op), w[4], w[2], w[4], w[4]);
            send_operands(3'(op), w[2], w[3], w[2], w[1]);
        end
        send_operands(gfa_pkg::OP_SUB, w[0], 64'd0, w[1], 64'd0);
        send_operands(gfa_pkg::OP_ESUB, w[3], w[0], w[4], w[1]);
        send_operands(gfa_pkg::OP_EMUL, w[0], w[2], w[0], w[2]);
        send_operands(gfa_pkg::OP_MUL, 64'h0000_0001_0000_0000, 64'd0,
                      64'h0000_0001_0000_0000, 64'd0);
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0)
                send_operands(op, edge_word(), edge_word(), edge_word(), edge_word());
            else
                send_operands(op, {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // result checker and sink back-pressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata[63:0] !== expected_results[0][63:0])
                begin
                    $display("%0t: res_real expected %h actual %h", $time,
                             expected_results[0][63:0], m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== expected_results[0][127:64])
                begin
                    $display("%0t: res_imag expected %h actual %h", $time,
                             expected_results[0][127:64], m_tdata[127:64]);
                    errors++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("goldilocks_field_alu_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_off = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_drain_pause();
        test_random(700);
        idle_off = 1'b1;
        test_random(250);
        test_drain_pause();
        repeat (gfa_pkg::STAGES + 10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("goldilocks_field_alu_unit_tb: done, clean");
        else
            $display("goldilocks_field_alu_unit_tb: done, errors");
        $finish;
    end
endmodule
